### src/pctd_pkg.sv
package pctd_pkg;

  // One decoded result as it travels from the front end to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } res_t;

  // Front end to queue: write strobe plus the result it writes.
  typedef struct packed {
    logic push;
    res_t res;
  } push_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

### src/pctd_in_if.sv
interface pctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

### src/pctd_out_if.sv
interface pctd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       decode_error;
  logic       out_last;

  modport source (output valid, output out_byte, output decode_error, output out_last,
                  input ready);
  modport sink (input valid, input out_byte, input decode_error, input out_last,
                output ready);
endinterface

### src/pctd_front.sv
module pctd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            query_mode,
  pctd_in_if.sink         in_ch,
  input  logic            q_full,
  output pctd_pkg::push_t push_o
);
  import pctd_pkg::*;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_AFTER_PCT = 2'd1;
  localparam logic [1:0] PH_AFTER_HI = 2'd2;
  localparam logic [1:0] PH_DROP     = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Bit 4 set means not a hex digit; bits 3:0 hold the digit value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    begin
      if (c >= 8'h30 && c <= 8'h39) begin
        v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
        v = {1'b0, c[3:0] + 4'd9};
      end else begin
        v = 5'h10;
      end
      hex_val = v;
    end
  endfunction

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic       accept;
  logic [4:0] hv;
  logic       last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign hv          = hex_val(in_ch.in_byte);
  assign last        = in_ch.in_last;

  always_comb begin
    phase_nxt   = phase_r;
    hi_nxt      = hi_r;
    push_o      = '0;
    if (accept) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_ch.in_byte == CH_PERCENT) begin
            if (last) begin
              push_o.push     = 1'b1;
              push_o.res.err  = 1'b1;
              push_o.res.last = 1'b1;
            end else begin
              phase_nxt = PH_AFTER_PCT;
            end
          end else begin
            push_o.push      = 1'b1;
            push_o.res.last  = last;
            push_o.res.data  = (in_ch.in_byte == CH_PLUS && query_mode) ? CH_SPACE
                                                                       : in_ch.in_byte;
          end
        end
        PH_AFTER_PCT: begin
          if (hv[4] || last) begin
            phase_nxt       = last ? PH_IDLE : PH_DROP;
            hi_nxt          = 4'd0;
            push_o.push     = 1'b1;
            push_o.res.err  = 1'b1;
            push_o.res.last = 1'b1;
          end else begin
            hi_nxt    = hv[3:0];
            phase_nxt = PH_AFTER_HI;
          end
        end
        PH_AFTER_HI: begin
          hi_nxt      = 4'd0;
          push_o.push = 1'b1;
          if (hv[4]) begin
            phase_nxt       = last ? PH_IDLE : PH_DROP;
            push_o.res.err  = 1'b1;
            push_o.res.last = 1'b1;
          end else begin
            phase_nxt       = PH_IDLE;
            push_o.res.data = {hi_r, hv[3:0]};
            push_o.res.last = last;
          end
        end
        PH_DROP: begin
          if (last) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hi_r    <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
    end
  end

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.push && push_o.res.err |-> push_o.res.data == 8'h00 && push_o.res.last)
    else $error("error result not zero or not last");

  a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DROP |-> !push_o.push)
    else $error("result produced while dropping");

endmodule

### src/pctd_fifo.sv
module pctd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  pctd_pkg::push_t push_i,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output pctd_pkg::res_t  head
);
  import pctd_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    begin
      ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    end
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_i.push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push_i.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_i.push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

### src/pctd_back.sv
module pctd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  input  pctd_pkg::res_t head,
  output logic           pop,
  pctd_out_if.source     out_ch
);
  import pctd_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r;

  // Refill the output register whenever it is empty or being drained.
  assign pop = !empty && (!vld_r || out_ch.ready);

  always_comb begin
    vld_nxt = vld_r;
    if (pop) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_ch.valid        = vld_r;
  assign out_ch.out_byte     = res_r.data;
  assign out_ch.decode_error = res_r.err;
  assign out_ch.out_last     = res_r.last;

endmodule

### src/percent_decoder_top.sv
// Channel | Dir | Handshake         | Beat contents
// --------+-----+-------------------+------------------------------------------
// in_ch   | in  | valid/ready       | in_byte[7:0], in_last
// out_ch  | out | valid/ready       | out_byte[7:0], decode_error, out_last
// cfg     | in  | cfg_we, no stall  | cfg_wdata = query_mode
//
// One input beat is taken per cycle while the two-entry result queue has room.
// A result passes through a queue entry and then the output register before it shows on out_ch.
// Throughput is set by the queue count: ready drops only when both entries hold.
// rst_n is synchronous and active low; it clears the phase machine, the queue
// and the output valid. query_mode resets to path decoding.
// A stall on out_ch backs up into the queue, then into in_ch ready.
module percent_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  pctd_in_if.sink    in_ch,
  pctd_out_if.source out_ch
);
  import pctd_pkg::*;

  // Decoding mode: 0 keeps '+', 1 turns '+' into a space.
  logic  query_mode_r;

  // Front end to queue.
  push_t front_push;
  logic  q_full;

  // Queue to output stage.
  logic  q_empty;
  logic  q_pop;
  res_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_mode_r <= 1'b0;
    end else if (cfg_we) begin
      query_mode_r <= cfg_wdata;
    end
  end

  // Classify each byte and track the escape phase; push at most one result.
  pctd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .query_mode (query_mode_r),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_o     (front_push)
  );

  // Decouple the front end from output stalls.
  pctd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (front_push),
    .pop    (q_pop),
    .full   (q_full),
    .empty  (q_empty),
    .head   (q_head)
  );

  // Hold each result in the output register until the sink takes it.
  pctd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule
